>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(name, expr)
`define ASSERT_NEXT(name, ante, cons)
`endif

`endif

>>> hdl/lbcd_pkg.sv
// ----------------------------------------------------------------------------
// lbcd_pkg
// Shared types, constants and helpers of the lower-bound circulation solver.
// ----------------------------------------------------------------------------
package lbcd_pkg;

  localparam int MaxNodes = 16;
  localparam int MaxEdges = 32;
  localparam int NodeW    = 4;
  localparam int EdgeW    = 5;
  localparam int CntW     = 6;
  localparam int CapW     = 16;
  localparam int LevW     = 5;
  localparam int SumW     = 21;
  localparam int SpW      = 5;
  localparam int ArcW     = 8;
  localparam int ArcDepth = 256;
  localparam int CfgW     = 4;

  localparam logic [NodeW-1:0] MaxOrdNode = 4'd14;
  localparam logic [NodeW-1:0] NodeCountReset = 4'd14;

  localparam logic [1:0] STAT_FEASIBLE   = 2'd0;
  localparam logic [1:0] STAT_INFEASIBLE = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW   = 2'd2;

  typedef struct packed {
    logic [3:0]  edge_from;
    logic [3:0]  edge_to;
    logic [15:0] lower_bound;
    logic [15:0] upper_bound;
    logic        last_edge;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  edge_index;
    logic [15:0] edge_flow;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic             rev;
    logic [EdgeW-1:0] k;
    logic [1:0]       t;
  } arc_t;

  typedef struct packed {
    logic done;
    arc_t a;
  } carc_t;

  typedef struct packed {
    logic [NodeW-1:0] from;
    logic [NodeW-1:0] to;
    logic [CapW-1:0]  low;
    logic [CapW-1:0]  span;
  } edge_t;

  typedef struct packed {
    arc_t             a;
    logic [NodeW-1:0] tail;
    logic [CapW-1:0]  cap;
  } stk_t;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [LevW-1:0]  enc;
  } qent_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_BLD_RD, ST_BLD_WR, ST_BFS_INIT, ST_BFS_POP, ST_BFS_ISS, ST_BFS_EVL,
    ST_DFS_INIT, ST_DFS_ISS, ST_DFS_EVL, ST_DFS_ADV, ST_AUG_MIN, ST_AUG_A, ST_AUG_B,
    ST_CHECK, ST_OUT_RD0, ST_OUT_RD1, ST_OUT_SUM, ST_EMIT_OVF, ST_EMIT_INF
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_BLD_RD, OP_BLD_WR, OP_BFS_INIT, OP_BFS_POP, OP_ARC_SCAN,
    OP_BFS_EVL, OP_DFS_INIT, OP_DFS_RD, OP_DFS_EVL, OP_POP, OP_DFS_ADV, OP_AUG_START,
    OP_AUG_MIN, OP_AUG_A, OP_AUG_B, OP_OUT_INIT, OP_OUT_RD0, OP_OUT_RD1, OP_OUT_WAIT,
    OP_OUT_PUT, OP_EMIT_OVF, OP_EMIT_INF
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic accept;
    logic in_last;
    logic ovf_next;
    logic sub_last;
    logic k_last;
    logic bad;
    logic q_nonempty;
    logic sink_hit;
    logic scan_last;
    logic u_is_sink;
    logic cur_done;
    logic sp_zero;
    logic sp_one;
    logic total_ok;
    logic out_free;
  } dp_stat_t;

  function automatic carc_t arc_next(carc_t c, logic [CntW-1:0] m);
    carc_t            r;
    logic [EdgeW-1:0] kl;
    r  = c;
    kl = EdgeW'(m - 1'b1);
    if (c.a.t != 2'd2) begin
      r.a.t = c.a.t + 2'd1;
    end else begin
      r.a.t = 2'd0;
      if (c.a.k != kl) begin
        r.a.k = c.a.k + 1'b1;
      end else begin
        r.a.k = '0;
        if (c.a.rev) begin
          r.done = 1'b1;
        end else begin
          r.a.rev = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic arc_t arc_pair(arc_t a);
    arc_t r;
    r     = a;
    r.rev = ~a.rev;
    return r;
  endfunction

endpackage

>>> hdl/lbcd_ctrl.sv
// ----------------------------------------------------------------------------
// lbcd_ctrl
// Sequencer: load, arc build, level search, blocking-flow search, readout, error results.
// ----------------------------------------------------------------------------
module lbcd_ctrl import lbcd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (stat_i.accept && stat_i.in_last) begin
          state_d = stat_i.ovf_next ? ST_EMIT_OVF : ST_BLD_RD;
        end
      end
      ST_BLD_RD: state_d = ST_BLD_WR;
      ST_BLD_WR: begin
        if (stat_i.sub_last) begin
          if (!stat_i.k_last) begin
            state_d = ST_BLD_RD;
          end else begin
            state_d = stat_i.bad ? ST_EMIT_INF : ST_BFS_INIT;
          end
        end
      end
      ST_BFS_INIT: state_d = ST_BFS_POP;
      ST_BFS_POP: begin
        if (stat_i.q_nonempty) begin
          state_d = ST_BFS_ISS;
        end else begin
          state_d = stat_i.sink_hit ? ST_DFS_INIT : ST_CHECK;
        end
      end
      ST_BFS_ISS: state_d = ST_BFS_EVL;
      ST_BFS_EVL: state_d = stat_i.scan_last ? ST_BFS_POP : ST_BFS_ISS;
      ST_DFS_INIT: state_d = ST_DFS_ISS;
      ST_DFS_ISS: begin
        if (stat_i.u_is_sink) begin
          state_d = ST_AUG_MIN;
        end else if (!stat_i.cur_done) begin
          state_d = ST_DFS_EVL;
        end else if (stat_i.sp_zero) begin
          state_d = ST_BFS_INIT;
        end else begin
          state_d = ST_DFS_ADV;
        end
      end
      ST_DFS_EVL: state_d = ST_DFS_ISS;
      ST_DFS_ADV: state_d = ST_DFS_ISS;
      ST_AUG_MIN: begin
        if (stat_i.sp_one) begin
          state_d = ST_AUG_A;
        end
      end
      ST_AUG_A: state_d = ST_AUG_B;
      ST_AUG_B: state_d = stat_i.sp_one ? ST_DFS_ISS : ST_AUG_A;
      ST_CHECK: state_d = stat_i.total_ok ? ST_OUT_RD0 : ST_EMIT_INF;
      ST_OUT_RD0: state_d = ST_OUT_RD1;
      ST_OUT_RD1: state_d = ST_OUT_SUM;
      ST_OUT_SUM: begin
        if (stat_i.out_free) begin
          state_d = stat_i.k_last ? ST_IDLE : ST_OUT_RD0;
        end
      end
      ST_EMIT_OVF, ST_EMIT_INF: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = OP_NONE;
    case (state_q)
      ST_IDLE:     cmd_o.op = OP_LOAD;
      ST_BLD_RD:   cmd_o.op = OP_BLD_RD;
      ST_BLD_WR:   cmd_o.op = OP_BLD_WR;
      ST_BFS_INIT: cmd_o.op = OP_BFS_INIT;
      ST_BFS_POP:  cmd_o.op = OP_BFS_POP;
      ST_BFS_ISS:  cmd_o.op = OP_ARC_SCAN;
      ST_BFS_EVL:  cmd_o.op = OP_BFS_EVL;
      ST_DFS_INIT: cmd_o.op = OP_DFS_INIT;
      ST_DFS_ISS: begin
        if (stat_i.u_is_sink) begin
          cmd_o.op = OP_AUG_START;
        end else if (!stat_i.cur_done) begin
          cmd_o.op = OP_DFS_RD;
        end else if (!stat_i.sp_zero) begin
          cmd_o.op = OP_POP;
        end
      end
      ST_DFS_EVL:  cmd_o.op = OP_DFS_EVL;
      ST_DFS_ADV:  cmd_o.op = OP_DFS_ADV;
      ST_AUG_MIN:  cmd_o.op = OP_AUG_MIN;
      ST_AUG_A:    cmd_o.op = OP_AUG_A;
      ST_AUG_B:    cmd_o.op = OP_AUG_B;
      ST_CHECK:    cmd_o.op = stat_i.total_ok ? OP_OUT_INIT : OP_NONE;
      ST_OUT_RD0:  cmd_o.op = OP_OUT_RD0;
      ST_OUT_RD1:  cmd_o.op = OP_OUT_RD1;
      ST_OUT_SUM:  cmd_o.op = stat_i.out_free ? OP_OUT_PUT : OP_OUT_WAIT;
      ST_EMIT_OVF: cmd_o.op = stat_i.out_free ? OP_EMIT_OVF : OP_NONE;
      ST_EMIT_INF: cmd_o.op = stat_i.out_free ? OP_EMIT_INF : OP_NONE;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

endmodule

>>> hdl/lbcd_dp.sv
// ----------------------------------------------------------------------------
// lbcd_dp
// Datapath: edge store, arc memories, level table, queue, path stack, output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbcd_dp import lbcd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dp_cmd_t         cmd_i,
  output dp_stat_t        stat_o,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_data_i,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_data_o
);

  logic [CfgW-1:0]  nc_q;
  logic [CntW-1:0]  m_q;
  logic [SumW-1:0]  lbsum_q, total_q;
  logic             ovf_q, bad_q, sink_hit_q, out_valid_q;
  logic [EdgeW-1:0] kk_q;
  logic [2:0]       sub_q;
  logic [SpW-1:0]   qh_q, qt_q, sp_q, sd_q;
  logic [NodeW-1:0] u_q;
  logic [LevW-1:0]  lev_q;
  logic [CapW-1:0]  b_q, f0_q;
  carc_t            a_q;
  logic [LevW-1:0]  enc_q [MaxNodes];
  carc_t            cur_q [MaxNodes];
  qent_t            qu_q  [MaxNodes];
  stk_t             stk_q [MaxNodes];
  edge_t            edge_mem [MaxEdges];
  edge_t            ed_q;
  logic [CapW-1:0]  cap_mem [ArcDepth];
  logic [7:0]       ep_mem  [ArcDepth];
  logic [CapW-1:0]  cap_rd_q;
  logic [7:0]       ep_rd_q;
  out_item_t        out_q;

  logic [NodeW-1:0] n_eff, sink, v, tl;
  logic             accept, cond_bfs, cond_dfs, k_last, clear_run, bad_edge;
  logic [CapW-1:0]  lo, hi;
  logic [SpW-1:0]   sp_m1;
  stk_t             top;
  carc_t            cur_u;
  carc_t            a_nx;
  logic [LevW-1:0]  enc_v, lev_p1;
  arc_t             rd_addr, wr_addr, bld_arc;
  logic             cap_we, ep_we;
  logic [CapW-1:0]  cap_wd;
  logic [7:0]       ep_wd;
  logic [CapW:0]    flow_sum;

  assign n_eff    = (nc_q > MaxOrdNode) ? MaxOrdNode : nc_q;
  assign sink     = n_eff + 1'b1;
  assign accept   = in_valid_i && (cmd_i.op == OP_LOAD);
  assign lo       = in_data_i.lower_bound;
  assign hi       = in_data_i.upper_bound;
  assign sp_m1    = sp_q - 1'b1;
  assign top      = stk_q[sp_m1[NodeW-1:0]];
  assign cur_u    = cur_q[u_q];
  assign a_nx     = arc_next(a_q, m_q);
  assign v        = ep_rd_q[3:0];
  assign tl       = ep_rd_q[7:4];
  assign enc_v    = enc_q[v];
  assign lev_p1   = lev_q + 1'b1;
  assign k_last   = (kk_q == EdgeW'(m_q - 1'b1));
  assign flow_sum = {1'b0, f0_q} + {1'b0, cap_rd_q};
  assign bad_edge = (ed_q.from == '0) || (ed_q.from > n_eff) ||
                    (ed_q.to == '0) || (ed_q.to > n_eff);

  assign cond_bfs = (tl == u_q) && (cap_rd_q != '0) && (enc_v == '0) && !qt_q[SpW-1];
  assign cond_dfs = (tl == u_q) && (cap_rd_q != '0) && (enc_v != '0) &&
                    (enc_v == lev_p1) && !sp_q[SpW-1];

  assign clear_run = ((cmd_i.op == OP_OUT_PUT) && k_last) ||
                     (cmd_i.op == OP_EMIT_OVF) || (cmd_i.op == OP_EMIT_INF);

  always_comb begin
    bld_arc.rev = (sub_q >= 3'd3);
    bld_arc.k   = kk_q;
    bld_arc.t   = bld_arc.rev ? 2'(sub_q - 3'd3) : sub_q[1:0];
  end

  always_comb begin
    case (cmd_i.op)
      OP_DFS_RD:  rd_addr = cur_u.a;
      OP_AUG_A:   rd_addr = arc_pair(top.a);
      OP_OUT_RD0: rd_addr = '{rev: 1'b1, k: kk_q, t: 2'd0};
      OP_OUT_RD1, OP_OUT_WAIT, OP_OUT_PUT: rd_addr = '{rev: 1'b1, k: kk_q, t: 2'd1};
      default:    rd_addr = a_q.a;
    endcase
  end

  always_comb begin
    cap_we  = 1'b0;
    ep_we   = 1'b0;
    wr_addr = bld_arc;
    cap_wd  = '0;
    ep_wd   = '0;
    case (cmd_i.op)
      OP_BLD_WR: begin
        cap_we = 1'b1;
        ep_we  = 1'b1;
        case (sub_q)
          3'd0: begin
            cap_wd = ed_q.span;
            ep_wd  = {ed_q.from, ed_q.to};
          end
          3'd1: begin
            cap_wd = ed_q.low;
            ep_wd  = {4'd0, ed_q.to};
          end
          3'd2: begin
            cap_wd = ed_q.low;
            ep_wd  = {ed_q.from, sink};
          end
          3'd3:    ep_wd = {ed_q.to, ed_q.from};
          3'd4:    ep_wd = {ed_q.to, 4'd0};
          default: ep_wd = {sink, ed_q.from};
        endcase
      end
      OP_AUG_A: begin
        cap_we  = 1'b1;
        wr_addr = top.a;
        cap_wd  = top.cap - b_q;
      end
      OP_AUG_B: begin
        cap_we  = 1'b1;
        wr_addr = arc_pair(top.a);
        cap_wd  = cap_rd_q + b_q;
      end
      default: begin
        cap_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cap_rd_q <= cap_mem[rd_addr];
    ep_rd_q  <= ep_mem[rd_addr];
    if (cap_we) begin
      cap_mem[wr_addr] <= cap_wd;
    end
    if (ep_we) begin
      ep_mem[wr_addr] <= ep_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    ed_q <= edge_mem[kk_q];
    if (accept && !m_q[CntW-1]) begin
      edge_mem[m_q[EdgeW-1:0]] <= '{from: in_data_i.edge_from, to: in_data_i.edge_to,
                                    low: lo, span: (hi > lo) ? hi - lo : '0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q        <= NodeCountReset;
      m_q         <= '0;
      lbsum_q     <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      bad_q       <= 1'b0;
      sink_hit_q  <= 1'b0;
      out_valid_q <= 1'b0;
      kk_q        <= '0;
      sub_q       <= '0;
      qh_q        <= '0;
      qt_q        <= '0;
      sp_q        <= '0;
      sd_q        <= '0;
      u_q         <= '0;
      lev_q       <= '0;
      b_q         <= '0;
      a_q         <= '0;
      for (int i = 0; i < MaxNodes; i++) begin
        enc_q[i] <= '0;
        cur_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        nc_q <= cfg_wdata_i;
      end
      if (cmd_i.op == OP_OUT_PUT || cmd_i.op == OP_EMIT_OVF || cmd_i.op == OP_EMIT_INF) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_LOAD: begin
          kk_q  <= '0;
          sub_q <= '0;
          if (accept) begin
            if (!m_q[CntW-1]) begin
              m_q     <= m_q + 1'b1;
              lbsum_q <= lbsum_q + SumW'(lo);
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        OP_BLD_RD: sub_q <= '0;
        OP_BLD_WR: begin
          if (bad_edge) begin
            bad_q <= 1'b1;
          end
          if (sub_q == 3'd5) begin
            sub_q <= '0;
            kk_q  <= kk_q + 1'b1;
          end else begin
            sub_q <= sub_q + 1'b1;
          end
        end
        OP_BFS_INIT: begin
          for (int i = 1; i < MaxNodes; i++) begin
            enc_q[i] <= '0;
          end
          enc_q[0]   <= LevW'(1);
          qh_q       <= '0;
          qt_q       <= SpW'(1);
          sink_hit_q <= 1'b0;
        end
        OP_BFS_POP: begin
          if (qh_q < qt_q) begin
            u_q   <= qu_q[qh_q[NodeW-1:0]].node;
            lev_q <= qu_q[qh_q[NodeW-1:0]].enc;
            qh_q  <= qh_q + 1'b1;
            a_q   <= '0;
          end
        end
        OP_BFS_EVL: begin
          if (cond_bfs) begin
            enc_q[v] <= lev_p1;
            qt_q     <= qt_q + 1'b1;
            if (v == sink) begin
              sink_hit_q <= 1'b1;
            end
          end
          a_q <= a_nx;
        end
        OP_DFS_INIT: begin
          for (int i = 0; i < MaxNodes; i++) begin
            cur_q[i] <= '0;
          end
          u_q   <= '0;
          lev_q <= LevW'(1);
          sp_q  <= '0;
        end
        OP_DFS_EVL: begin
          if (cond_dfs) begin
            sp_q  <= sp_q + 1'b1;
            u_q   <= v;
            lev_q <= lev_p1;
          end else begin
            cur_q[u_q] <= arc_next(cur_u, m_q);
          end
        end
        OP_POP: begin
          u_q   <= top.tail;
          lev_q <= lev_q - 1'b1;
          sp_q  <= sp_m1;
        end
        OP_DFS_ADV: cur_q[u_q] <= arc_next(cur_u, m_q);
        OP_AUG_START: begin
          b_q  <= '1;
          sd_q <= sp_q;
        end
        OP_AUG_MIN: begin
          if (top.cap < b_q) begin
            b_q <= top.cap;
          end
          sp_q <= (sp_q == SpW'(1)) ? sd_q : sp_m1;
        end
        OP_AUG_B: begin
          sp_q <= sp_m1;
          if (sp_q == SpW'(1)) begin
            total_q <= total_q + SumW'(b_q);
            u_q     <= '0;
            lev_q   <= LevW'(1);
          end
        end
        OP_OUT_INIT: kk_q <= '0;
        OP_OUT_PUT:  kk_q <= kk_q + 1'b1;
        default: begin
          kk_q <= kk_q;
        end
      endcase
      if (clear_run) begin
        m_q     <= '0;
        lbsum_q <= '0;
        total_q <= '0;
        ovf_q   <= 1'b0;
        bad_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_BFS_INIT) begin
      qu_q[0] <= '{node: '0, enc: LevW'(1)};
    end
    if (cmd_i.op == OP_BFS_EVL && cond_bfs) begin
      qu_q[qt_q[NodeW-1:0]] <= '{node: v, enc: lev_p1};
    end
    if (cmd_i.op == OP_DFS_EVL && cond_dfs) begin
      stk_q[sp_q[NodeW-1:0]] <= '{a: cur_u.a, tail: u_q, cap: cap_rd_q};
    end
    if (cmd_i.op == OP_OUT_RD1) begin
      f0_q <= cap_rd_q;
    end
    case (cmd_i.op)
      OP_OUT_PUT: out_q <= '{status: STAT_FEASIBLE, edge_index: kk_q,
                             edge_flow: flow_sum[CapW-1:0], last_result: k_last};
      OP_EMIT_OVF: out_q <= '{status: STAT_OVERFLOW, edge_index: '0,
                              edge_flow: '0, last_result: 1'b1};
      OP_EMIT_INF: out_q <= '{status: STAT_INFEASIBLE, edge_index: '0,
                              edge_flow: '0, last_result: 1'b1};
      default: out_q <= out_q;
    endcase
  end

  assign in_ready_o  = (cmd_i.op == OP_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    stat_o.accept     = accept;
    stat_o.in_last    = in_data_i.last_edge;
    stat_o.ovf_next   = ovf_q | m_q[CntW-1];
    stat_o.sub_last   = (sub_q == 3'd5);
    stat_o.k_last     = k_last;
    stat_o.bad        = bad_q;
    stat_o.q_nonempty = (qh_q < qt_q);
    stat_o.sink_hit   = sink_hit_q;
    stat_o.scan_last  = a_nx.done;
    stat_o.u_is_sink  = (u_q == sink);
    stat_o.cur_done   = cur_u.done;
    stat_o.sp_zero    = (sp_q == '0);
    stat_o.sp_one     = (sp_q == SpW'(1));
    stat_o.total_ok   = (total_q == lbsum_q);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  `ASSERT_ALWAYS(a_stack_depth, sp_q <= SpW'(MaxNodes))
  `ASSERT_ALWAYS(a_queue_order, qh_q <= qt_q)
  `ASSERT_ALWAYS(a_flow_bound, total_q <= lbsum_q)
  `ASSERT_NEXT(a_result_shown, cmd_i.op == OP_OUT_PUT, out_valid_q)

endmodule

>>> hdl/lower_bound_circulation_dinic.sv
// ----------------------------------------------------------------------------
// lower_bound_circulation_dinic
// Feasible circulation with lower and upper edge bounds via Dinic max flow.
// ----------------------------------------------------------------------------
// Edges load one per cycle while the solver is idle; a non-final edge gives no result.
// The final edge starts a solve: arcs are built for each edge, then each phase takes
// nodes from the level queue and scans their arcs, searches paths arc by arc along the
// levels and augments along each path found.
// Readout sums two arcs per edge; input is held off until the last result is issued.
// rst_ni clears control state asynchronously; node_count resets to 14.
module lower_bound_circulation_dinic import lbcd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_data_o,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lbcd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  lbcd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> tb/lower_bound_circulation_dinic_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lower_bound_circulation_dinic_tb
// Loads runs of bounded edges and checks every flow row, infeasible answer and
// overflow answer against a Dinic circulation solver kept in the bench. Sender
// bursts, receiver stalls and a long receiver hold-off exercise the handshakes.
// ----------------------------------------------------------------------------
module lower_bound_circulation_dinic_tb;
  import lbcd_pkg::*;

  localparam int WatchLimit = 2000000;
  localparam int ArcMax     = 6 * MaxEdges;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  in_item_t        in_data_i;
  logic            out_valid_o;
  logic            out_ready_i;
  out_item_t       out_data_o;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;

  lower_bound_circulation_dinic uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // solver state
  logic [3:0]  node_cnt;
  int          edges_held;
  longint      low_sum;
  longint      flow_sum;
  bit          edge_ovf;
  logic [3:0]  ed_from [MaxEdges];
  logic [3:0]  ed_to [MaxEdges];
  longint      ed_low [MaxEdges];
  longint      ed_span [MaxEdges];
  int          arc_tl [ArcMax];
  int          arc_hd [ArcMax];
  longint      res_cap [ArcMax];
  int          lvl [MaxNodes];
  bit          seen [MaxNodes];
  int          cur_arc [MaxNodes];
  int          path_stk [MaxNodes];
  int          lvl_q [MaxNodes];

  out_item_t   flow_rows_q [$];
  int          errors;
  int          items_sent;
  int          idle_cycles;
  bit          hold_off;
  bit          no_gaps;
  int          burst_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void expect_row(out_item_t r);
    flow_rows_q = {flow_rows_q, r};
  endfunction

  function automatic bit build_levels(int arcs, int sink);
    int qh, qt, u, v;
    qh = 0;
    qt = 0;
    for (int i = 0; i < MaxNodes; i++) begin
      seen[i] = 0;
      lvl[i]  = 0;
    end
    seen[0] = 1;
    lvl_q[qt++] = 0;
    while (qh < qt) begin
      u = lvl_q[qh++];
      for (int a = 0; a < arcs; a++) begin
        v = arc_hd[a];
        if (arc_tl[a] == u && v < MaxNodes && !seen[v] && res_cap[a] > 0 &&
            qt < MaxNodes) begin
          seen[v]     = 1;
          lvl[v]      = lvl[u] + 1;
          lvl_q[qt++] = v;
        end
      end
    end
    return sink < MaxNodes && seen[sink];
  endfunction

  function automatic void push_blocking(int arcs, int sink, int half);
    int     depth, u, a, v, e, p;
    longint b;
    depth = 0;
    for (int i = 0; i < MaxNodes; i++) cur_arc[i] = 0;
    while (1) begin
      u = depth ? arc_hd[path_stk[depth-1]] : 0;
      if (u == sink) begin
        b = 64'h7fff_ffff_ffff_ffff;
        for (int i = 0; i < depth; i++)
          if (res_cap[path_stk[i]] < b) b = res_cap[path_stk[i]];
        for (int i = 0; i < depth; i++) begin
          e = path_stk[i];
          p = (e < half) ? e + half : e - half;
          res_cap[e] -= b;
          res_cap[p] += b;
        end
        flow_sum += b;
        depth = 0;
        continue;
      end
      if (cur_arc[u] < arcs) begin
        a = cur_arc[u];
        v = arc_hd[a];
        if (arc_tl[a] == u && res_cap[a] > 0 && v < MaxNodes && seen[v] &&
            lvl[v] == lvl[u] + 1 && depth < MaxNodes)
          path_stk[depth++] = a;
        else
          cur_arc[u]++;
        continue;
      end
      if (depth == 0) break;
      depth--;
      cur_arc[depth ? arc_hd[path_stk[depth-1]] : 0]++;
    end
  endfunction

  function automatic void close_run(logic [1:0] st);
    out_item_t r;
    if (st != STAT_FEASIBLE) begin
      r.status      = st;
      r.edge_index  = '0;
      r.edge_flow   = '0;
      r.last_result = 1'b1;
      expect_row(r);
    end
    edges_held = 0;
    low_sum    = 0;
    flow_sum   = 0;
    edge_ovf   = 0;
  endfunction

  function automatic void solve_edge(in_item_t it);
    int        n, m, sink, half, arcs, k;
    longint    lo, hi;
    out_item_t r;
    lo = longint'(it.lower_bound);
    hi = longint'(it.upper_bound);
    if (edges_held < MaxEdges) begin
      k = edges_held++;
      ed_from[k] = it.edge_from;
      ed_to[k]   = it.edge_to;
      ed_low[k]  = lo;
      ed_span[k] = (hi > lo) ? hi - lo : 0;
      low_sum   += lo;
    end else begin
      edge_ovf = 1;
    end
    if (!it.last_edge) return;
    if (edge_ovf) begin
      close_run(STAT_OVERFLOW);
      return;
    end
    n = (node_cnt > MaxOrdNode) ? int'(MaxOrdNode) : int'(node_cnt);
    m = edges_held;
    for (k = 0; k < m; k++)
      if (ed_from[k] < 1 || ed_from[k] > n || ed_to[k] < 1 || ed_to[k] > n) begin
        close_run(STAT_INFEASIBLE);
        return;
      end
    sink = n + 1;
    half = 3 * m;
    arcs = 6 * m;
    for (k = 0; k < m; k++) begin
      arc_tl[3*k]    = int'(ed_from[k]);
      arc_hd[3*k]    = int'(ed_to[k]);
      res_cap[3*k]   = ed_span[k];
      arc_tl[3*k+1]  = 0;
      arc_hd[3*k+1]  = int'(ed_to[k]);
      res_cap[3*k+1] = ed_low[k];
      arc_tl[3*k+2]  = int'(ed_from[k]);
      arc_hd[3*k+2]  = sink;
      res_cap[3*k+2] = ed_low[k];
    end
    for (k = 0; k < half; k++) begin
      arc_tl[half+k]  = arc_hd[k];
      arc_hd[half+k]  = arc_tl[k];
      res_cap[half+k] = 0;
    end
    flow_sum = 0;
    while (build_levels(arcs, sink)) push_blocking(arcs, sink, half);
    if (flow_sum != low_sum) begin
      close_run(STAT_INFEASIBLE);
      return;
    end
    for (k = 0; k < m; k++) begin
      r.status      = STAT_FEASIBLE;
      r.edge_index  = 5'(k);
      r.edge_flow   = 16'(res_cap[half+3*k] + res_cap[half+3*k+1]);
      r.last_result = (k + 1 == m);
      expect_row(r);
    end
    close_run(STAT_FEASIBLE);
  endfunction

  // sender: bursts with random gaps; valid held across back-to-back transfers
  task automatic send_edge(logic [3:0] f, logic [3:0] t, logic [15:0] lo,
                           logic [15:0] hi, logic last);
    in_item_t it;
    int       gap;
    it.edge_from   = f;
    it.edge_to     = t;
    it.lower_bound = lo;
    it.upper_bound = hi;
    it.last_edge   = last;
    if (!no_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    solve_edge(it);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (flow_rows_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_nodes(logic [3:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    node_cnt  = v;
  endtask

  // a ring through random nodes, optionally with fully random edges mixed in
  task automatic send_run(int m, bit noisy);
    int n, a, b;
    logic [15:0] lo, hi;
    n = (node_cnt > MaxOrdNode) ? int'(MaxOrdNode) : int'(node_cnt);
    a = $urandom_range(1, n);
    for (int k = 0; k < m; k++) begin
      if (noisy && $urandom_range(0, 3) == 0) begin
        send_edge(4'($urandom), 4'($urandom), 16'($urandom), 16'($urandom), k == m - 1);
        continue;
      end
      b  = (k == m - 1) ? a : $urandom_range(1, n);
      lo = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40));
      hi = $urandom_range(0, 7) == 0 ? 16'($urandom_range(0, 40)) :
                                       16'(lo + $urandom_range(0, 60));
      send_edge(4'(a), 4'(b), lo, hi, k == m - 1);
      a = b;
    end
  endtask

  task automatic test_directed();
    set_nodes(4'd14);
    send_edge(4'd1, 4'd1, 16'd5, 16'd10, 1'b1);
    send_edge(4'd1, 4'd2, 16'd3, 16'd9, 1'b0);
    send_edge(4'd2, 4'd1, 16'd1, 16'd4, 1'b1);
    send_edge(4'd1, 4'd14, 16'hffff, 16'hffff, 1'b0);
    send_edge(4'd14, 4'd1, 16'hffff, 16'hffff, 1'b1);
    send_edge(4'd3, 4'd4, 16'd20, 16'd7, 1'b0);
    send_edge(4'd4, 4'd3, 16'd0, 16'd30, 1'b1);
    send_edge(4'd0, 4'd2, 16'd0, 16'd5, 1'b1);
    send_edge(4'd2, 4'd15, 16'd0, 16'd5, 1'b1);
    send_edge(4'd5, 4'd6, 16'd10, 16'd10, 1'b0);
    send_edge(4'd6, 4'd5, 16'd0, 16'd0, 1'b1);
    send_edge(4'd7, 4'd8, 16'd0, 16'hffff, 1'b1);
    drain();
    set_nodes(4'd1);
    send_edge(4'd1, 4'd1, 16'd0, 16'hffff, 1'b0);
    send_edge(4'd1, 4'd2, 16'd0, 16'd1, 1'b1);
    drain();
  endtask

  task automatic test_overflow();
    set_nodes(4'd6);
    for (int k = 0; k < MaxEdges + 2; k++)
      send_edge(4'(k % 6 + 1), 4'((k + 1) % 6 + 1), 16'd1, 16'd3, k == MaxEdges + 1);
    send_run(MaxEdges, 1'b0);
    drain();
  endtask

  task automatic test_random_runs(int goal);
    logic [3:0] cfgs [4] = '{4'd15, 4'd3, 4'd9, 4'd14};
    int c;
    c = 0;
    while (items_sent < goal) begin
      if ($urandom_range(0, 5) == 0) begin
        drain();
        set_nodes(cfgs[c % 4]);
        c++;
      end
      no_gaps = ($urandom_range(0, 4) == 0);
      send_run($urandom_range(0, 29) == 0 ? MaxEdges : $urandom_range(1, 6),
               $urandom_range(0, 5) == 0);
    end
    no_gaps = 0;
    drain();
  endtask

  task automatic test_backpressure();
    set_nodes(4'd8);
    fork
      begin
        hold_off = 1;
        repeat (500) @(posedge clk_i);
        hold_off = 0;
      end
      for (int r = 0; r < 4; r++) send_run(5, 1'b0);
    join
    drain();
  endtask

  // receiver: stall pattern picked at random from three modes; ready held low during hold-off
  initial begin
    int cyc;
    int mode;
    cyc = 0;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      cyc++;
      if (hold_off) out_ready_i <= 1'b0;
      else if (mode == 0) out_ready_i <= 1'b1;
      else if (mode == 1) out_ready_i <= $urandom_range(0, 1);
      else out_ready_i <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (flow_rows_q.size() == 0) begin
        report_mismatch("unexpected result, status", longint'(out_data_o.status), -1);
      end else begin
        want = flow_rows_q.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch("status", longint'(out_data_o.status), longint'(want.status));
        if (out_data_o.edge_index !== want.edge_index)
          report_mismatch("edge_index", longint'(out_data_o.edge_index),
                          longint'(want.edge_index));
        if (out_data_o.edge_flow !== want.edge_flow)
          report_mismatch("edge_flow", longint'(out_data_o.edge_flow),
                          longint'(want.edge_flow));
        if (out_data_o.last_result !== want.last_result)
          report_mismatch("last_result", longint'(out_data_o.last_result),
                          longint'(want.last_result));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WatchLimit) begin
      $display("lower_bound_circulation_dinic_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    idle_cycles = 0;
    errors      = 0;
    items_sent  = 0;
    hold_off    = 0;
    no_gaps     = 0;
    burst_left  = 0;
    node_cnt    = NodeCountReset;
    edges_held  = 0;
    low_sum     = 0;
    flow_sum    = 0;
    edge_ovf    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_backpressure();
    test_random_runs(280);
    if (errors == 0 && flow_rows_q.size() == 0) begin
      $display("lower_bound_circulation_dinic_tb: PASS");
    end else begin
      $display("lower_bound_circulation_dinic_tb: FAIL");
    end
    $finish;
  end

endmodule
